/* rtl/cdfe_pkg.sv */
`default_nettype none

package cdfe_pkg;

    localparam int HISTORY_DEPTH = 9;
    localparam int MAX_COEFFS    = 16;

    // fixed field widths
    localparam int DATA_W     = 32;
    localparam int POS_W      = 4;
    localparam int COUNT_W    = 5;
    localparam int WIN_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // derived geometry
    localparam int SLOT_W     = $clog2(HISTORY_DEPTH);
    localparam int SLOT_EW    = SLOT_W + 1;
    localparam int HELD_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int COEFF_W    = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
    localparam int CMP_W      = COEFF_W + COUNT_W;
    localparam int RAM_DEPTH  = HISTORY_DEPTH * MAX_COEFFS;
    localparam int ADDR_W     = $clog2(RAM_DEPTH);
    localparam int WIN_MAX    = (HISTORY_DEPTH / 2 < 7) ? HISTORY_DEPTH / 2 : 7;
    localparam int CENTRE_AGE = HISTORY_DEPTH - 1 - HISTORY_DEPTH / 2;
    localparam int DEN_MAX    = WIN_MAX * (WIN_MAX + 1) * (2 * WIN_MAX + 1) / 3;
    localparam int DEN_W      = $clog2(DEN_MAX + 1);
    localparam int NUM_W      = DATA_W + 2 + $clog2(WIN_MAX * (WIN_MAX + 1) / 2 + 1);
    localparam int D2_W       = DATA_W + 3;
    localparam int STEP_W     = $clog2(2 * WIN_MAX + 2);
    localparam int DIV_W      = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_W);

    localparam int COUNT_RST  = 13;
    localparam int WIN_RST    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEFF_COUNT = 2'd0,
        CFG_HALF_WIDTH  = 2'd1
    } t_cfg_idx;

    // ring slot of the frame 'age' frames older than the newest one
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] newest,
                                                  input logic [SLOT_W-1:0] age);
        logic [SLOT_EW-1:0] s;
        s = SLOT_EW'(newest) + SLOT_EW'(HISTORY_DEPTH) - SLOT_EW'(age);
        if (s >= SLOT_EW'(HISTORY_DEPTH)) begin
            s = s - SLOT_EW'(HISTORY_DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SLOT_W-1:0] slot,
                                                  input logic [COEFF_W-1:0] pos);
        return ADDR_W'(slot) * ADDR_W'(MAX_COEFFS) + ADDR_W'(pos);
    endfunction

    // 2 * sum of n^2 for n = 1..win
    function automatic logic [DEN_W-1:0] den_of(input logic [WIN_W-1:0] win);
        logic [DEN_W-1:0] sum;
        sum = '0;
        for (int i = 1; i <= WIN_MAX; i++) begin
            if (WIN_W'(i) <= win) begin
                sum = sum + DEN_W'(2 * i * i);
            end
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

/* rtl/cdfe_ram.sv */
`default_nettype none

module cdfe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/cepstral_delta_feature_engine_core.sv */
`default_nettype none

// Cepstral delta engine. Takes one signed Q16.16 coefficient per input transfer,
// stores it in a ring of the last 9 frames (16 coefficients each, 144-word RAM)
// and returns one result per coefficient: the value itself, the regression delta
// sum(n*(x[c+n]-x[c-n])) / (2*sum n^2) for n = 1..W, and the second difference
// x[c+1] - 2x[c] + x[c-1], both taken at the centre frame for the same
// coefficient index. Deltas truncate toward zero and saturate to 32 bits; both
// read as zero (history_full = 0) until 8 frames are complete. Register 0 is
// coeff_count (1..16, reset 13), register 1 is the regression half width W
// (1..4, reset 2); out-of-range values are clamped. Write configuration only
// while idle.
// Timing: the block takes one coefficient at a time. Before the history is full
// the input transfer goes straight to the output step, where the result is
// loaded into the output register. Once full, the
// single RAM read port fetches 2W+1 words at one per cycle, S_LAST drains the
// last read, S_SIGN loads the divider and a bit-serial divider works through
// the 38-bit magnitude in S_DIV before the result is loaded. After the load the
// block returns to idle and takes the next coefficient.
// A result held in the output register stalls the block in
// its last step until it is taken. RAM entries carry valid bits that reset
// clears, so no clearing pass is needed after reset.

module cepstral_delta_feature_engine_core
    import cdfe_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // coefficient in
    input  wire logic                  i_valid,
    output      logic                  o_ready,
    input  wire logic [DATA_W-1:0]     i_coeff_value,
    // result out
    output      logic                  o_valid,
    input  wire logic                  i_ready,
    output      logic [DATA_W-1:0]     o_coeff_out,
    output      logic [DATA_W-1:0]     o_delta_out,
    output      logic [DATA_W-1:0]     o_delta2_out,
    output      logic [POS_W-1:0]      o_coeff_position,
    output      logic                  o_frame_last,
    output      logic                  o_history_full,
    // configuration writes
    input  wire logic                  i_cfg_valid,
    output      logic                  o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,   // waiting for a coefficient
        S_READ = 6'b000010,   // issue window reads, one per cycle
        S_LAST = 6'b000100,   // last read returns
        S_SIGN = 6'b001000,   // take magnitude, load divider
        S_DIV  = 6'b010000,   // restoring divide, one bit per cycle
        S_OUT  = 6'b100000    // hand result to output register
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [COUNT_W-1:0] r_coeff_count;
    logic [WIN_W-1:0]   r_half_width;

    // ring bookkeeping
    logic [SLOT_W-1:0]  r_newest;
    logic [HELD_W-1:0]  r_held;
    logic [COEFF_W-1:0] r_pos;
    logic [RAM_DEPTH-1:0] r_entry_valid;

    // per-item context
    logic [DATA_W-1:0]  r_value;
    logic               r_last;
    logic               r_full;
    logic [WIN_W-1:0]   r_win;

    // read sequencer
    logic [STEP_W-1:0]  r_k;
    logic               r_ret_live;
    logic [WIN_W-1:0]   r_ret_n;
    logic               r_ret_plus;
    logic               r_ret_valid;

    // accumulators
    logic signed [NUM_W-1:0] r_num;
    logic signed [D2_W-1:0]  r_d2;

    // divider
    logic [DIV_W-1:0]     r_dq;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // output register
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_coeff;
    logic [DATA_W-1:0]  r_out_delta;
    logic [DATA_W-1:0]  r_out_delta2;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_last;
    logic               r_out_full;

    logic in_xfer;
    logic out_load;

    // ---------------------------------------------------------------
    // configuration port: always ready
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff_count <= COUNT_W'(COUNT_RST);
            r_half_width  <= WIN_W'(WIN_RST);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COEFF_COUNT: r_coeff_count <= i_cfg_data[COUNT_W-1:0];
                CFG_HALF_WIDTH:  r_half_width  <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // clamped settings and per-item decisions at the input transfer
    // ---------------------------------------------------------------
    logic [CMP_W-1:0] count_eff;
    logic [WIN_W-1:0] win_eff;
    logic             last_now;
    logic             full_now;

    always_comb begin
        if (r_coeff_count == '0) begin
            count_eff = CMP_W'(1);
        end else if (CMP_W'(r_coeff_count) > CMP_W'(MAX_COEFFS)) begin
            count_eff = CMP_W'(MAX_COEFFS);
        end else begin
            count_eff = CMP_W'(r_coeff_count);
        end

        if (r_half_width == '0) begin
            win_eff = WIN_W'(1);
        end else if (r_half_width > WIN_W'(WIN_MAX)) begin
            win_eff = WIN_W'(WIN_MAX);
        end else begin
            win_eff = r_half_width;
        end

        last_now = (CMP_W'(r_pos) + CMP_W'(1)) >= count_eff;
        full_now = r_held >= HELD_W'(HISTORY_DEPTH - 1);
    end

    assign o_ready = (r_state == S_IDLE);
    assign in_xfer = i_valid && o_ready;
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);

    // ---------------------------------------------------------------
    // read address: step k reads the centre (k = 0), then n = (k+1)/2,
    // odd k the newer side, even k the older side
    // ---------------------------------------------------------------
    logic [STEP_W-1:0] k_inc;
    logic [WIN_W-1:0]  iss_n;
    logic              iss_plus;
    logic [SLOT_W-1:0] iss_age;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              last_issue;

    always_comb begin
        k_inc    = r_k + STEP_W'(1);
        iss_n    = WIN_W'(k_inc >> 1);
        iss_plus = r_k[0];
        if (iss_plus) begin
            iss_age = SLOT_W'(CENTRE_AGE) - SLOT_W'(iss_n);
        end else begin
            iss_age = SLOT_W'(CENTRE_AGE) + SLOT_W'(iss_n);
        end
        rd_addr    = addr_of(slot_of(r_newest, iss_age), r_pos);
        wr_addr    = addr_of(r_newest, r_pos);
        last_issue = (r_k == STEP_W'({r_win, 1'b0}));
    end

    logic [DATA_W-1:0] ram_q;

    cdfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (wr_addr),
        .i_wdata (i_coeff_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer) n_state = full_now ? S_READ : S_OUT;
            S_READ: if (last_issue) n_state = S_LAST;
            S_LAST: n_state = S_SIGN;
            S_SIGN: n_state = S_DIV;
            S_DIV:  if (r_div_cnt == DIV_CNT_W'(DIV_W - 1)) n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item context and read step counter
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_value <= i_coeff_value;
            r_last  <= last_now;
            r_full  <= full_now;
            r_win   <= win_eff;
            r_k     <= '0;
        end else if (r_state == S_READ) begin
            r_k <= k_inc;
        end
    end

    // return tags line up with the registered RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ret_live <= 1'b0;
        end else begin
            r_ret_live <= (r_state == S_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret_n     <= iss_n;
        r_ret_plus  <= iss_plus;
        r_ret_valid <= r_entry_valid[rd_addr];
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (in_xfer) begin
            r_entry_valid[wr_addr] <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // accumulate window terms
    // ---------------------------------------------------------------
    logic signed [DATA_W-1:0] rd_word;
    logic signed [NUM_W-1:0]  term;
    logic signed [D2_W-1:0]   d2_word;

    always_comb begin
        rd_word = r_ret_valid ? $signed(ram_q) : '0;
        term    = NUM_W'(rd_word) * $signed(NUM_W'({1'b0, r_ret_n}));
        d2_word = D2_W'(rd_word);
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_num <= '0;
            r_d2  <= '0;
        end else if (r_ret_live) begin
            r_num <= r_ret_plus ? (r_num + term) : (r_num - term);
            if (r_ret_n == '0) begin
                r_d2 <= r_d2 - (d2_word <<< 1);
            end else if (r_ret_n == WIN_W'(1)) begin
                r_d2 <= r_d2 + d2_word;
            end
        end
    end

    // ---------------------------------------------------------------
    // restoring divider on the magnitude
    // ---------------------------------------------------------------
    logic [DEN_W:0]   rem_sh;
    logic             q_bit;
    logic [DEN_W-1:0] rem_next;

    always_comb begin
        rem_sh   = {r_rem, r_dq[DIV_W-1]};
        q_bit    = rem_sh >= {1'b0, r_den};
        rem_next = q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SIGN) begin
            r_neg     <= r_num[NUM_W-1];
            r_dq      <= r_num[NUM_W-1] ? DIV_W'(-r_num) : DIV_W'(r_num);
            r_rem     <= '0;
            r_den     <= den_of(r_win);
            r_div_cnt <= '0;
        end else if (r_state == S_DIV) begin
            r_dq      <= {r_dq[DIV_W-2:0], q_bit};
            r_rem     <= rem_next;
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // saturation to 32 bits
    // ---------------------------------------------------------------
    logic signed [DIV_W:0]    q_signed;
    logic [DIV_W-DATA_W+1:0]  q_top;
    logic [D2_W-DATA_W:0]     d2_top;
    logic [DATA_W-1:0]        delta_sat;
    logic [DATA_W-1:0]        delta2_sat;

    always_comb begin
        q_signed = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
        q_top    = q_signed[DIV_W:DATA_W-1];
        if ((&q_top) || !(|q_top)) begin
            delta_sat = q_signed[DATA_W-1:0];
        end else begin
            delta_sat = q_signed[DIV_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}};
        end

        d2_top = r_d2[D2_W-1:DATA_W-1];
        if ((&d2_top) || !(|d2_top)) begin
            delta2_sat = r_d2[DATA_W-1:0];
        end else begin
            delta2_sat = r_d2[D2_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                      : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    // ---------------------------------------------------------------
    // output register and frame bookkeeping
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_newest    <= '0;
            r_held      <= '0;
            r_pos       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            if (out_load) begin
                if (r_last) begin
                    r_pos <= '0;
                    if (r_newest == SLOT_W'(HISTORY_DEPTH - 1)) begin
                        r_newest <= '0;
                    end else begin
                        r_newest <= r_newest + SLOT_W'(1);
                    end
                    if (r_held < HELD_W'(HISTORY_DEPTH)) begin
                        r_held <= r_held + HELD_W'(1);
                    end
                end else begin
                    r_pos <= r_pos + COEFF_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_coeff  <= r_value;
            r_out_delta  <= r_full ? delta_sat : '0;
            r_out_delta2 <= r_full ? delta2_sat : '0;
            r_out_pos    <= POS_W'(r_pos);
            r_out_last   <= r_last;
            r_out_full   <= r_full;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_coeff_out      = r_out_coeff;
    assign o_delta_out      = r_out_delta;
    assign o_delta2_out     = r_out_delta2;
    assign o_coeff_position = r_out_pos;
    assign o_frame_last     = r_out_last;
    assign o_history_full   = r_out_full;

endmodule

`default_nettype wire

/* rtl/cdfe_chk.sv */
`default_nettype none

module cdfe_chk
    import cdfe_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_ready,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [DATA_W-1:0]     o_coeff_out,
    input wire logic [DATA_W-1:0]     o_delta_out,
    input wire logic [DATA_W-1:0]     o_delta2_out,
    input wire logic                  o_history_full
);

    // set once a full-history result has been transferred
    logic r_seen_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_full <= 1'b0;
        end else if (o_valid && i_ready && o_history_full) begin
            r_seen_full <= 1'b1;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_coeff_out)
                                   && $stable(o_delta_out) && $stable(o_delta2_out)))
        else $error("result changed while stalled");

    // deltas forced to zero before the history fills
    a_zero_until_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_history_full) |-> (o_delta_out == '0 && o_delta2_out == '0))
        else $error("nonzero delta without full history");

    // one coefficient at a time
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while busy");

    // history never empties again without reset
    a_full_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen_full && o_valid) |-> o_history_full)
        else $error("history_full dropped");

endmodule

bind cepstral_delta_feature_engine_core cdfe_chk u_cdfe_chk (.*);

`default_nettype wire
